### sv/kcct_pkg.sv
package kcct_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 256;

  localparam int unsigned IP_W     = 32;
  localparam int unsigned BUCKET_W = 2;
  localparam int unsigned CNT_W    = 32;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PROTO_W  = 8;

  localparam logic [CNT_W-1:0]   COUNT_MAX = '1;
  localparam logic [PROTO_W-1:0] PNUM_TCP  = 8'd6;
  localparam logic [PROTO_W-1:0] PNUM_UDP  = 8'd17;

  localparam logic [BUCKET_W-1:0] BKT_TCP   = 2'd0;
  localparam logic [BUCKET_W-1:0] BKT_UDP   = 2'd1;
  localparam logic [BUCKET_W-1:0] BKT_OTHER = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    STS_INC    = 3'd0,
    STS_NEW    = 3'd1,
    STS_DEC    = 3'd2,
    STS_ABSENT = 3'd3,
    STS_FULL   = 3'd4
  } upd_status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE
  } ctrl_state_t;

  // key layout: ip in the low bits, then bucket, then direction
  typedef struct packed {
    logic                dir;
    logic [BUCKET_W-1:0] bucket;
    logic [IP_W-1:0]     ip;
  } key_t;

  typedef struct packed {
    logic             valid;
    key_t             key;
    logic [CNT_W-1:0] cnt;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic scan_run;
    logic do_write;
    logic next_side;
    logic clr_run;
  } kcct_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic out_free;
    logic side_dst;
  } kcct_sts_t;

  function automatic logic [BUCKET_W-1:0] to_bucket(input logic [PROTO_W-1:0] proto);
    logic [BUCKET_W-1:0] b;
    if (proto == PNUM_TCP) begin
      b = BKT_TCP;
    end else if (proto == PNUM_UDP) begin
      b = BKT_UDP;
    end else begin
      b = BKT_OTHER;
    end
    return b;
  endfunction

endpackage

### sv/kcct_ctrl.sv
module kcct_ctrl
  import kcct_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  kcct_sts_t sts,
  output kcct_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        if (sts.scan_done) state_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          state_nxt = sts.side_dst ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr_run = 1'b1;
      end
      ST_IDLE: begin
        in_tready      = 1'b1;
        cmd.load       = in_tvalid;
        cmd.scan_start = in_tvalid;
      end
      ST_SCAN: begin
        cmd.scan_run = !sts.scan_done;
      end
      ST_WRITE: begin
        if (sts.out_free) begin
          cmd.do_write = 1'b1;
          // source side done, go look up the destination key
          if (!sts.side_dst) begin
            cmd.next_side  = 1'b1;
            cmd.scan_start = 1'b1;
          end
        end
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### sv/kcct_datapath.sv
module kcct_datapath
  import kcct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  kcct_cmd_t        cmd,
  output kcct_sts_t        sts,
  input  logic [71:0]      in_tdata,
  input  logic             in_tuser,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,
  output logic             out_tlast
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  entry_t mem [TABLE_ENTRIES];

  // event registers
  logic                is_del_r;
  logic [IP_W-1:0]     src_r;
  logic [IP_W-1:0]     dst_r;
  logic [BUCKET_W-1:0] bucket_r;
  logic                dir_r;

  // scan state
  logic [IDX_W-1:0] addr_r;
  logic             issue_done_r;
  logic             pend_r;
  logic [IDX_W-1:0] tag_r;
  entry_t           rd_data_r;
  logic             hit_r;
  logic [IDX_W-1:0] hit_idx_r;
  logic [CNT_W-1:0] hit_cnt_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;

  // result register
  logic                out_valid_r;
  logic [IP_W-1:0]     o_addr_r;
  logic [BUCKET_W-1:0] o_bucket_r;
  logic                o_dir_r;
  logic [CNT_W-1:0]    o_cnt_r;
  upd_status_t         o_status_r;

  key_t        cur_key;
  logic        rd_en;
  logic        wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t      wr_data;
  logic [CNT_W-1:0] new_cnt;
  upd_status_t new_status;

  assign cur_key.dir    = dir_r;
  assign cur_key.bucket = bucket_r;
  assign cur_key.ip     = dir_r ? dst_r : src_r;

  assign rd_en = cmd.scan_run && !issue_done_r;

  // update decision from the finished scan
  always_comb begin
    wr_en      = 1'b0;
    wr_addr    = hit_idx_r;
    wr_data    = '0;
    new_cnt    = '0;
    new_status = STS_FULL;
    if (hit_r) begin
      if (is_del_r) begin
        new_cnt    = hit_cnt_r - CNT_W'(1);
        new_status = STS_DEC;
      end else begin
        new_cnt    = (hit_cnt_r == COUNT_MAX) ? hit_cnt_r : hit_cnt_r + CNT_W'(1);
        new_status = STS_INC;
      end
      wr_en         = 1'b1;
      wr_data.valid = (new_cnt != '0);
      wr_data.key   = cur_key;
      wr_data.cnt   = new_cnt;
    end else if (is_del_r) begin
      new_status = STS_ABSENT;
    end else if (free_found_r) begin
      new_cnt       = CNT_W'(1);
      new_status    = STS_NEW;
      wr_en         = 1'b1;
      wr_addr       = free_idx_r;
      wr_data.valid = 1'b1;
      wr_data.key   = cur_key;
      wr_data.cnt   = CNT_W'(1);
    end
  end

  // table memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (cmd.clr_run) begin
      mem[addr_r] <= '0;
    end else if (cmd.do_write && wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[addr_r];
      tag_r     <= addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      is_del_r <= in_tuser;
      src_r    <= in_tdata[31:0];
      dst_r    <= in_tdata[63:32];
      bucket_r <= to_bucket(in_tdata[71:64]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r        <= 1'b0;
      addr_r       <= '0;
      issue_done_r <= 1'b0;
      pend_r       <= 1'b0;
      hit_r        <= 1'b0;
      hit_idx_r    <= '0;
      hit_cnt_r    <= '0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
    end else begin
      if (cmd.load) begin
        dir_r <= 1'b0;
      end else if (cmd.next_side) begin
        dir_r <= 1'b1;
      end

      if (cmd.clr_run) begin
        addr_r <= (addr_r == LAST_IDX) ? '0 : addr_r + IDX_W'(1);
      end else if (cmd.scan_start) begin
        addr_r       <= '0;
        issue_done_r <= 1'b0;
        pend_r       <= 1'b0;
        hit_r        <= 1'b0;
        free_found_r <= 1'b0;
      end else begin
        pend_r <= rd_en;
        if (rd_en) begin
          if (addr_r == LAST_IDX) begin
            addr_r       <= '0;
            issue_done_r <= 1'b1;
          end else begin
            addr_r <= addr_r + IDX_W'(1);
          end
        end
        // compare stage on the entry read last cycle
        if (pend_r && !hit_r) begin
          if (rd_data_r.valid && rd_data_r.key == cur_key) begin
            hit_r     <= 1'b1;
            hit_idx_r <= tag_r;
            hit_cnt_r <= rd_data_r.cnt;
          end else if (!rd_data_r.valid && !free_found_r) begin
            free_found_r <= 1'b1;
            free_idx_r   <= tag_r;
          end
        end
      end
    end
  end

  // result beat register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.do_write) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.do_write) begin
      o_addr_r   <= cur_key.ip;
      o_bucket_r <= bucket_r;
      o_dir_r    <= dir_r;
      o_cnt_r    <= new_cnt;
      o_status_r <= new_status;
    end
  end

  assign sts.clr_last  = (addr_r == LAST_IDX);
  assign sts.scan_done = hit_r || (issue_done_r && !pend_r);
  assign sts.out_free  = !out_valid_r || out_tready;
  assign sts.side_dst  = dir_r;

  assign out_tvalid = out_valid_r;
  assign out_tlast  = o_dir_r;
  assign out_tdata  = {2'b00, o_status_r, o_cnt_r, o_dir_r, o_bucket_r, o_addr_r};

endmodule

### sv/keyed_connection_counter_table_unit.sv
// Per-key connection counter table. Each input beat is one connection event
// (insert or delete) and yields two result beats: first the source address
// key, then the destination address key (tlast high). Keys live in a table
// memory with one write port and one registered read port that is searched
// one entry per clock; each of the two updates searches the table (it stops
// early at a match), then writes back and loads the result. No new event is
// taken until both updates are written back. The write-back waits while the
// output register still holds a beat that has not been taken. After reset
// the table is cleared one entry per cycle, during which no event is taken.
// A finished result sits in an output register, so a new event can be taken
// while the last result still waits.
module keyed_connection_counter_table_unit
  import kcct_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // src_ip[31:0], dst_ip[63:32], protocol_number[71:64]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  // address[31:0], bucket[33:32], direction[34], count[66:35], status[69:67], zero pad
  output logic [71:0] out_tdata,
  output logic        out_tlast
);

  kcct_cmd_t cmd;
  kcct_sts_t sts;

  kcct_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  kcct_datapath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

### verif/tb_keyed_connection_counter_table_unit.sv
module tb_keyed_connection_counter_table_unit;
  import kcct_pkg::*;

  localparam int unsigned NUM_SLOTS     = TABLE_ENTRIES_DEF;
  localparam int unsigned SETTLE_CYCLES = 2 * (NUM_SLOTS + 3) + 20;
  localparam int unsigned HOLD_CYCLES   = 1500;
  localparam longint      CYCLE_LIMIT   = 4_000_000;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;
  localparam logic DIR_SRC     = 1'b0;
  localparam logic DIR_DST     = 1'b1;

  typedef struct {
    logic                mode;
    logic [IP_W-1:0]     src;
    logic [IP_W-1:0]     dst;
    logic [PROTO_W-1:0]  proto;
  } conn_event_t;

  typedef struct {
    logic [IP_W-1:0]     address;
    logic [BUCKET_W-1:0] bucket;
    logic                dir;
    logic [CNT_W-1:0]    count;
    upd_status_t         status;
    logic                last;
  } key_report_t;

  // status and count given by hand only where they are obvious
  typedef struct packed {
    logic               mode;
    logic [IP_W-1:0]    src;
    logic [IP_W-1:0]    dst;
    logic [PROTO_W-1:0] proto;
    logic               known;
    upd_status_t        st_src;
    logic [CNT_W-1:0]   cnt_src;
    upd_status_t        st_dst;
    logic [CNT_W-1:0]   cnt_dst;
  } directed_row_t;

  localparam int NUM_ROWS = 22;
  localparam directed_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    '{MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, PNUM_TCP, 1'b1, STS_NEW, 32'd1, STS_NEW, 32'd1},
    '{MODE_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, PNUM_TCP, 1'b1, STS_INC, 32'd2, STS_INC, 32'd2},
    '{MODE_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, PNUM_TCP, 1'b1, STS_DEC, 32'd1, STS_DEC, 32'd1},
    '{MODE_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, PNUM_TCP, 1'b1, STS_DEC, 32'd0, STS_DEC, 32'd0},
    '{MODE_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, PNUM_TCP, 1'b1,
      STS_ABSENT, 32'd0, STS_ABSENT, 32'd0},
    '{MODE_INSERT, 32'h0A00_0001, 32'h0A00_0001, PNUM_UDP, 1'b1, STS_NEW, 32'd1, STS_NEW, 32'd1},
    '{MODE_INSERT, 32'h0A00_0001, 32'h0A00_0001, 8'd0, 1'b1, STS_NEW, 32'd1, STS_NEW, 32'd1},
    '{MODE_INSERT, 32'h0A00_0001, 32'h0A00_0001, 8'd255, 1'b1, STS_INC, 32'd2, STS_INC, 32'd2},
    '{MODE_INSERT, 32'h0A00_0001, 32'h0A00_0001, 8'd16, 1'b0, STS_INC, 32'd0, STS_INC, 32'd0},
    '{MODE_INSERT, 32'h0A00_0001, 32'h0A00_0002, 8'd18, 1'b0, STS_INC, 32'd0, STS_INC, 32'd0},
    '{MODE_DELETE, 32'h0A00_0001, 32'h1234_5678, PNUM_UDP, 1'b1,
      STS_DEC, 32'd0, STS_ABSENT, 32'd0},
    '{MODE_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 8'd5, 1'b0, STS_INC, 32'd0, STS_INC, 32'd0},
    '{MODE_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 8'd7, 1'b0, STS_INC, 32'd0, STS_INC, 32'd0},
    '{MODE_INSERT, 32'h8000_0000, 32'h7FFF_FFFF, PNUM_TCP, 1'b0,
      STS_INC, 32'd0, STS_INC, 32'd0},
    '{MODE_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, PNUM_TCP, 1'b1, STS_NEW, 32'd1, STS_NEW, 32'd1},
    '{MODE_DELETE, 32'hFFFF_FFFF, 32'h0000_0000, PNUM_TCP, 1'b1, STS_DEC, 32'd0, STS_DEC, 32'd0},
    '{MODE_DELETE, 32'h0000_0000, 32'hFFFF_FFFF, PNUM_UDP, 1'b1,
      STS_ABSENT, 32'd0, STS_ABSENT, 32'd0},
    '{MODE_DELETE, 32'h0A00_0001, 32'h0A00_0001, 8'd255, 1'b0, STS_INC, 32'd0, STS_INC, 32'd0},
    '{MODE_DELETE, 32'h5555_5555, 32'hAAAA_AAAA, 8'd200, 1'b0, STS_INC, 32'd0, STS_INC, 32'd0},
    '{MODE_INSERT, 32'h0A00_0001, 32'h0A00_0001, PNUM_TCP, 1'b1, STS_NEW, 32'd1, STS_NEW, 32'd1},
    '{MODE_INSERT, 32'hDEAD_BEEF, 32'h0102_0304, 8'd128, 1'b0, STS_INC, 32'd0, STS_INC, 32'd0},
    '{MODE_DELETE, 32'hDEAD_BEEF, 32'h0102_0304, 8'd128, 1'b0, STS_INC, 32'd0, STS_INC, 32'd0}
  };

  localparam logic [IP_W-1:0] ADDR_POOL [16] = '{
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0A00_0001, 32'h0A00_0002,
    32'hC0A8_0001, 32'hC0A8_00FE, 32'h7F00_0001, 32'h8000_0000,
    32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0808_0808,
    32'hAC10_0A01, 32'h0000_0001, 32'hFFFF_FFFE, 32'h6400_0040
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;   // src_ip[31:0], dst_ip[63:32], protocol_number[71:64]
  logic        in_tuser;   // mode
  logic        out_tvalid;
  logic        out_tready;
  // address[31:0], bucket[33:32], direction[34], count[66:35], status[69:67], zero pad
  logic [71:0] out_tdata;
  logic        out_tlast;

  // shadow of the key table
  logic             tbl_used [NUM_SLOTS];
  key_t             tbl_key  [NUM_SLOTS];
  logic [CNT_W-1:0] tbl_hits [NUM_SLOTS];

  key_report_t pending_reports [$];
  int          mismatches;
  longint      cycle_count;
  bit          steady;
  bit          hold_off_req;

  keyed_connection_counter_table_unit #(
    .TABLE_ENTRIES(NUM_SLOTS)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic logic [BUCKET_W-1:0] bucket_of(input logic [PROTO_W-1:0] proto);
    case (proto)
      PNUM_TCP: return BKT_TCP;
      PNUM_UDP: return BKT_UDP;
      default:  return BKT_OTHER;
    endcase
  endfunction

  // one match-and-modify pass over the shadow table
  function automatic upd_status_t apply_key(input key_t k, input logic is_del,
                                            output logic [CNT_W-1:0] cnt);
    int free_idx;
    bit have_free;
    free_idx  = 0;
    have_free = 1'b0;
    cnt       = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_used[i]) begin
        if (tbl_key[i] == k) begin
          if (is_del) begin
            tbl_hits[i] = tbl_hits[i] - CNT_W'(1);
            if (tbl_hits[i] == '0) tbl_used[i] = 1'b0;
            cnt = tbl_hits[i];
            return STS_DEC;
          end
          if (tbl_hits[i] != COUNT_MAX) tbl_hits[i] = tbl_hits[i] + CNT_W'(1);
          cnt = tbl_hits[i];
          return STS_INC;
        end
      end else if (!have_free) begin
        have_free = 1'b1;
        free_idx  = i;
      end
    end
    if (is_del) return STS_ABSENT;
    if (!have_free) return STS_FULL;
    tbl_used[free_idx] = 1'b1;
    tbl_key[free_idx]  = k;
    tbl_hits[free_idx] = CNT_W'(1);
    cnt = CNT_W'(1);
    return STS_NEW;
  endfunction

  task automatic record_event(input conn_event_t ev, input bit known,
                              input upd_status_t st_s, input logic [CNT_W-1:0] cnt_s,
                              input upd_status_t st_d, input logic [CNT_W-1:0] cnt_d);
    logic [BUCKET_W-1:0] b;
    logic [CNT_W-1:0]    c;
    upd_status_t         st;
    key_report_t         rep;
    b  = bucket_of(ev.proto);
    st = apply_key('{dir: DIR_SRC, bucket: b, ip: ev.src}, ev.mode == MODE_DELETE, c);
    rep.address = ev.src;
    rep.bucket  = b;
    rep.dir     = DIR_SRC;
    rep.count   = known ? cnt_s : c;
    rep.status  = known ? st_s : st;
    rep.last    = 1'b0;
    pending_reports.push_back(rep);
    st = apply_key('{dir: DIR_DST, bucket: b, ip: ev.dst}, ev.mode == MODE_DELETE, c);
    rep.address = ev.dst;
    rep.dir     = DIR_DST;
    rep.count   = known ? cnt_d : c;
    rep.status  = known ? st_d : st;
    rep.last    = 1'b1;
    pending_reports.push_back(rep);
  endtask

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [IP_W-1:0] pick_addr(input int fresh_pct);
    if ($urandom_range(0, 99) < fresh_pct) return $urandom;
    return ADDR_POOL[$urandom_range(0, 15)];
  endfunction

  function automatic logic [PROTO_W-1:0] pick_proto_for(input logic [BUCKET_W-1:0] b);
    logic [PROTO_W-1:0] p;
    if (b == BKT_TCP) return PNUM_TCP;
    if (b == BKT_UDP) return PNUM_UDP;
    p = PROTO_W'($urandom_range(0, 255));
    while (p == PNUM_TCP || p == PNUM_UDP) p = PROTO_W'($urandom_range(0, 255));
    return p;
  endfunction

  // deletes aimed at a live key reach the decrement and removal paths
  function automatic conn_event_t make_event(input int ins_pct, input int live_pct,
                                             input int fresh_pct);
    conn_event_t ev;
    int          r;
    int          start;
    int          idx;
    bit          found;
    ev.mode = ($urandom_range(0, 99) < ins_pct) ? MODE_INSERT : MODE_DELETE;
    ev.src  = pick_addr(fresh_pct);
    ev.dst  = pick_addr(fresh_pct);
    r = $urandom_range(0, 99);
    if (r < 40) ev.proto = PNUM_TCP;
    else if (r < 70) ev.proto = PNUM_UDP;
    else ev.proto = PROTO_W'($urandom_range(0, 255));
    if (ev.mode == MODE_DELETE && $urandom_range(0, 99) < live_pct) begin
      start = $urandom_range(0, NUM_SLOTS - 1);
      found = 1'b0;
      idx   = start;
      for (int n = 0; n < NUM_SLOTS && !found; n++) begin
        idx = (start + n) % NUM_SLOTS;
        if (tbl_used[idx]) found = 1'b1;
      end
      if (found) begin
        ev.proto = pick_proto_for(tbl_key[idx].bucket);
        if (tbl_key[idx].dir == DIR_SRC) ev.src = tbl_key[idx].ip;
        else ev.dst = tbl_key[idx].ip;
      end
    end
    return ev;
  endfunction

  task automatic push_event(input conn_event_t ev, input bit known,
                            input upd_status_t st_s, input logic [CNT_W-1:0] cnt_s,
                            input upd_status_t st_d, input logic [CNT_W-1:0] cnt_d);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {ev.proto, ev.dst, ev.src};
    in_tuser  <= ev.mode;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    record_event(ev, known, st_s, cnt_s, st_d, cnt_d);
  endtask

  task automatic run_phase(input int n_items, input int ins_pct, input int live_pct,
                           input int fresh_pct);
    for (int i = 0; i < n_items; i++) begin
      push_event(make_event(ins_pct, live_pct, fresh_pct), 1'b0, STS_INC, '0, STS_INC, '0);
    end
  endtask

  task automatic wait_all_reported();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  initial begin
    conn_event_t   ev;
    directed_row_t row;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    steady       = 1'b0;
    hold_off_req = 1'b0;
    mismatches   = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i]  = '0;
      tbl_hits[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      row      = DIRECTED_ROWS[i];
      ev.mode  = row.mode;
      ev.src   = row.src;
      ev.dst   = row.dst;
      ev.proto = row.proto;
      push_event(ev, row.known, row.st_src, row.cnt_src, row.st_dst, row.cnt_dst);
    end
    wait_all_reported();

    // receiver holds off while events keep coming, so the input side backs up
    hold_off_req = 1'b1;
    steady       = 1'b1;
    run_phase(100, 55, 50, 10);
    steady = 1'b0;
    run_phase(250, 55, 50, 10);
    wait_all_reported();

    // mostly fresh inserts: fills the table and then drops
    run_phase(350, 90, 60, 90);
    wait_all_reported();

    // mostly deletes of live keys, then a mixed phase
    run_phase(350, 15, 85, 30);
    run_phase(250, 50, 50, 20);
    wait_all_reported();

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    int len;
    int gap;
    out_tready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      len = $urandom_range(1, 20);
      out_tready <= 1'b1;
      repeat (len) @(posedge clk);
      gap = pick_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  task automatic check_field(input string name, input logic [CNT_W-1:0] exp_val,
                             input logic [CNT_W-1:0] act_val);
    if (exp_val !== act_val) begin
      $error("%s: expected %0h, got %0h", name, exp_val, act_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    key_report_t exp_rep;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reports.size() == 0) begin
        $error("result beat with nothing pending: address %0h", out_tdata[31:0]);
        mismatches++;
      end else begin
        exp_rep = pending_reports.pop_front();
        check_field("address", exp_rep.address, out_tdata[31:0]);
        check_field("bucket", CNT_W'(exp_rep.bucket), CNT_W'(out_tdata[33:32]));
        check_field("direction", CNT_W'(exp_rep.dir), CNT_W'(out_tdata[34]));
        check_field("count", exp_rep.count, out_tdata[66:35]);
        check_field("status", CNT_W'(exp_rep.status), CNT_W'(out_tdata[69:67]));
        check_field("pad", '0, CNT_W'(out_tdata[71:70]));
        check_field("last", CNT_W'(exp_rep.last), CNT_W'(out_tlast));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b0 && cycle_count == 0) begin
      cycle_count <= 1;
    end else begin
      cycle_count <= cycle_count + 1;
    end
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial cycle_count = 0;

endmodule
